// ===== design/two_sum_pair_finder_assert.svh =====
// Shared assertion macros; every user has clk and rst_n in scope.
`ifndef TWO_SUM_PAIR_FINDER_ASSERT_SVH
`define TWO_SUM_PAIR_FINDER_ASSERT_SVH

// Same-cycle implication.
`define TSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("two_sum_pair_finder: check failed");

// Next-cycle implication.
`define TSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("two_sum_pair_finder: check failed");

`endif

// ===== design/tsp_pkg.sv =====
package tsp_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int VAL_W     = 32;
    localparam int TGT_W     = 33;
    localparam int POS_W     = 7;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        STATUS_PAIR = 2'd0,
        STATUS_NONE = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    // One stored element as it moves down the row.
    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
    } tsp_entry_t;

    // Search keys broadcast to every cell.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] comp;
        logic             comp_ok;
    } tsp_key_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } tsp_ctrl_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] hit_pos;
        logic             dup;
    } tsp_match_t;

endpackage

// ===== design/two_sum_pair_finder.sv =====
// Streaming two-sum pair finder.
// Input channel (in_valid / in_stall, value, last_item): one signed element of
// a set per transfer; last_item marks the final element of the set.
// Output channel (out_valid / out_stall, status, earlier_position,
// later_position): at most one result per set - a pair (status 0, with both
// 1-based positions), no pair (1) or capacity exceeded (2) at the set's end.
// cfg_write loads target_sum; write it only while the block is idle.
// Throughput: one element per cycle unless the output stalls. Each element
// is compared against all 64 stored entries at once by the row of cells; an
// insert shifts the row by one cell in the same cycle as that compare.
// A result is registered in the output register once the element that caused
// it has passed through the input stage.
// A stalled result holds the output register; the element behind it waits in
// the input stage and in_stall rises only when that stage is also occupied.
// Reset clears target_sum, the store and all per-set status; no clearing pass
// is needed, and the store is also emptied at once at the end of every set.
`include "two_sum_pair_finder_assert.svh"

module two_sum_pair_finder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic signed [tsp_pkg::TGT_W-1:0] target_sum,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [tsp_pkg::VAL_W-1:0] value,
    input  logic                             last_item,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       status,
    output logic [tsp_pkg::POS_W-1:0]        earlier_position,
    output logic [tsp_pkg::POS_W-1:0]        later_position
);
    import tsp_pkg::*;

    logic [TGT_W-1:0] target_reg;

    logic             s1_valid_reg;
    logic             s1_last_reg;
    logic [VAL_W-1:0] s1_value_reg;
    logic [VAL_W-1:0] s1_comp_reg;
    logic             s1_comp_ok_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             pair_reg, pair_next;
    logic             cap_reg, cap_next;

    logic             out_valid_reg, out_valid_next;
    status_t          status_reg;
    logic [POS_W-1:0] early_reg;
    logic [POS_W-1:0] late_reg;

    logic             blocked;
    logic             proc;
    logic             full;
    logic [POS_W-1:0] new_pos;
    logic [VAL_W+1:0] comp_wide;
    logic             comp_ok;

    logic             res_valid;
    status_t          res_status;
    logic [POS_W-1:0] res_early;
    logic [POS_W-1:0] res_late;

    tsp_ctrl_t        ctrl;
    tsp_key_t         key;
    tsp_match_t       match;

    // Exact complement in 34 bits; only in-range values can match the store.
    assign comp_wide = {target_reg[TGT_W-1], target_reg} - {{2{value[VAL_W-1]}}, value};
    assign comp_ok   = (comp_wide[VAL_W+1] == comp_wide[VAL_W-1])
                    && (comp_wide[VAL_W] == comp_wide[VAL_W-1]);

    assign blocked  = out_valid_reg && out_stall;
    assign proc     = s1_valid_reg && !blocked;
    assign in_stall = s1_valid_reg && blocked;

    assign full    = count_reg >= CNT_W'(MAX_ITEMS);
    assign new_pos = POS_W'(count_reg + CNT_W'(1));

    assign key.value   = s1_value_reg;
    assign key.comp    = s1_comp_reg;
    assign key.comp_ok = s1_comp_ok_reg;

    tsp_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .key     (key),
        .new_pos (new_pos),
        .match   (match)
    );

    always_comb
    begin
        count_next = count_reg;
        pair_next  = pair_reg;
        cap_next   = cap_reg;
        ctrl       = '0;
        res_valid  = 1'b0;
        res_status = STATUS_PAIR;
        res_early  = '0;
        res_late   = '0;
        if (proc)
        begin
            if (!pair_reg)
            begin
                if (full)
                begin
                    // drop: store is full
                    cap_next = 1'b1;
                end
                else
                begin
                    if (match.hit)
                    begin
                        res_valid  = 1'b1;
                        res_status = STATUS_PAIR;
                        res_early  = match.hit_pos;
                        res_late   = new_pos;
                        pair_next  = 1'b1;
                    end
                    else if (!match.dup)
                    begin
                        ctrl.shift = 1'b1;
                    end
                    count_next = count_reg + CNT_W'(1);
                end
                if (s1_last_reg && !pair_next)
                begin
                    res_valid  = 1'b1;
                    res_status = cap_next ? STATUS_FULL : STATUS_NONE;
                end
            end
            if (s1_last_reg)
            begin
                ctrl.clear = 1'b1;
                count_next = '0;
                pair_next  = 1'b0;
                cap_next   = 1'b0;
            end
        end
        out_valid_next = res_valid || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            count_reg     <= '0;
            pair_reg      <= 1'b0;
            cap_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                target_reg <= target_sum;
            end
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            count_reg     <= count_next;
            pair_reg      <= pair_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_last_reg    <= last_item;
            s1_value_reg   <= value;
            s1_comp_reg    <= comp_wide[VAL_W-1:0];
            s1_comp_ok_reg <= comp_ok;
        end
        if (res_valid)
        begin
            status_reg <= res_status;
            early_reg  <= res_early;
            late_reg   <= res_late;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign earlier_position = early_reg;
    assign later_position   = late_reg;

    `TSP_ASSERT_NOW(a_pair_positions, out_valid_reg && (status_reg == STATUS_PAIR),
                    (early_reg != '0) && (early_reg < late_reg))
    `TSP_ASSERT_NOW(a_nopair_positions, out_valid_reg && (status_reg != STATUS_PAIR),
                    (early_reg == '0) && (late_reg == '0))
    `TSP_ASSERT_NEXT(a_set_end_clears, proc && s1_last_reg,
                     (count_reg == '0) && !pair_reg && !cap_reg)
    `TSP_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ITEMS))

endmodule

// ===== design/tsp_cell.sv =====
module tsp_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  tsp_pkg::tsp_ctrl_t  ctrl,
    input  tsp_pkg::tsp_key_t   key,
    input  tsp_pkg::tsp_entry_t prev,
    output tsp_pkg::tsp_entry_t cur,
    output logic                comp_hit,
    output logic                dup
);
    import tsp_pkg::*;

    logic             valid_reg;
    logic [VAL_W-1:0] value_reg;
    logic [POS_W-1:0] pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= prev.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            value_reg <= prev.value;
            pos_reg   <= prev.pos;
        end
    end

    assign cur.valid = valid_reg;
    assign cur.value = value_reg;
    assign cur.pos   = pos_reg;

    assign comp_hit = valid_reg && key.comp_ok && (value_reg == key.comp);
    assign dup      = valid_reg && (value_reg == key.value);

endmodule

// ===== design/tsp_chain.sv =====
`include "two_sum_pair_finder_assert.svh"

module tsp_chain (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tsp_pkg::tsp_ctrl_t      ctrl,
    input  tsp_pkg::tsp_key_t       key,
    input  logic [tsp_pkg::POS_W-1:0] new_pos,
    output tsp_pkg::tsp_match_t     match
);
    import tsp_pkg::*;

    tsp_entry_t           link [0:MAX_ITEMS];
    logic [MAX_ITEMS-1:0] hit_vec;
    logic [MAX_ITEMS-1:0] dup_vec;
    logic [MAX_ITEMS-1:0] valid_vec;
    logic [POS_W-1:0]     pos_or;

    // New entries enter at the head and push older ones one cell along.
    assign link[0].valid = 1'b1;
    assign link[0].value = key.value;
    assign link[0].pos   = new_pos;

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        tsp_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .key      (key),
            .prev     (link[i]),
            .cur      (link[i+1]),
            .comp_hit (hit_vec[i]),
            .dup      (dup_vec[i])
        );
        assign valid_vec[i] = link[i+1].valid;
    end

    // Stored values are distinct, so at most one cell hits.
    always_comb
    begin
        pos_or = '0;
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            pos_or = pos_or | (link[i+1].pos & {POS_W{hit_vec[i]}});
        end
    end

    assign match.hit     = |hit_vec;
    assign match.hit_pos = pos_or;
    assign match.dup     = |dup_vec;

    `TSP_ASSERT_NOW(a_comp_hit_unique, 1'b1, $onehot0(hit_vec))
    `TSP_ASSERT_NOW(a_dup_unique, 1'b1, $onehot0(dup_vec))
    `TSP_ASSERT_NOW(a_valid_prefix, 1'b1,
                    ((valid_vec + MAX_ITEMS'(1)) & valid_vec) == '0)

endmodule

// ===== dv/tb_two_sum_pair_finder.sv =====
`timescale 1ns / 100ps

module tb_two_sum_pair_finder;
    import tsp_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int SETTLE_TICKS = 6;
    localparam int PHASE_ITEMS  = 220;

    typedef struct {
        status_t          status;
        logic [POS_W-1:0] earlier;
        logic [POS_W-1:0] later;
    } set_outcome_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic signed [TGT_W-1:0]  target_sum = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [VAL_W-1:0]  value = '0;
    logic                     last_item = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               status;
    logic [POS_W-1:0]         earlier_position;
    logic [POS_W-1:0]         later_position;

    // Shadow of the block: target, store and per-set status.
    logic signed [TGT_W-1:0]  target_q = '0;
    logic signed [VAL_W-1:0]  slot_value [MAX_ITEMS];
    logic [POS_W-1:0]         slot_pos [MAX_ITEMS];
    bit                       slot_used [MAX_ITEMS];
    int                       set_count = 0;
    bit                       pair_done = 1'b0;
    bit                       overflow = 1'b0;

    set_outcome_t             pending_outcomes [$];

    int                       error_count = 0;
    int                       elements_sent = 0;
    int                       elements_used = 0;
    int                       sets_sent = 0;
    int                       pairs_seen = 0;
    int                       nopair_seen = 0;
    int                       full_seen = 0;
    int                       quiet_cycles = 0;

    int                       tx_gap_max = 0;
    int                       burst_left = 0;
    int                       rx_mode = 0;
    int                       stall_left = 0;
    bit                       stall_on = 1'b0;

    two_sum_pair_finder i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .target_sum       (target_sum),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .value            (value),
        .last_item        (last_item),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .earlier_position (earlier_position),
        .later_position   (later_position)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic void clear_store();
        for (int k = 0; k < MAX_ITEMS; k++)
        begin
            slot_used[k] = 1'b0;
        end
        set_count = 0;
        pair_done = 1'b0;
        overflow  = 1'b0;
    endfunction

    function automatic int find_slot_of(input logic signed [VAL_W+1:0] key);
        for (int k = 0; k < MAX_ITEMS; k++)
        begin
            if (slot_used[k] && slot_value[k] == key)
                return k;
        end
        return -1;
    endfunction

    // Advance the shadow by one element; returns 1 when the element was looked at.
    function automatic bit predict_element(input logic signed [VAL_W-1:0] v, input logic lst);
        logic signed [VAL_W+1:0] need;
        int                      hit;
        bit                      used;
        used = 1'b0;
        if (!pair_done)
        begin
            if (set_count >= MAX_ITEMS)
            begin
                overflow = 1'b1;
            end
            else
            begin
                used = 1'b1;
                need = target_q - v;
                hit  = find_slot_of(need);
                if (hit >= 0)
                begin
                    pending_outcomes.push_back('{STATUS_PAIR, slot_pos[hit],
                                                 POS_W'(set_count + 1)});
                    pair_done = 1'b1;
                end
                else if (find_slot_of(v) < 0)
                begin
                    slot_value[set_count] = v;
                    slot_pos[set_count]   = POS_W'(set_count + 1);
                    slot_used[set_count]  = 1'b1;
                end
                set_count++;
            end
            if (lst && !pair_done)
                pending_outcomes.push_back('{overflow ? STATUS_FULL : STATUS_NONE, '0, '0});
        end
        if (lst)
            clear_store();
        return used;
    endfunction

    task automatic send_element(input logic signed [VAL_W-1:0] v, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            if (tx_gap_max > 0)
            begin
                gap = $urandom_range(1, tx_gap_max);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid  <= 1'b1;
        value     <= v;
        last_item <= lst;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        burst_left--;
        elements_sent++;
        if (lst)
            sets_sent++;
        if (predict_element(v, lst))
            elements_used++;
    endtask

    // Drop valid, wait for every outcome, then let the input stage empty.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic set_target(input logic signed [TGT_W-1:0] t);
        drain_block();
        cfg_write  <= 1'b1;
        target_sum <= t;
        @(posedge clk);
        cfg_write <= 1'b0;
        target_q = t;
    endtask

    task automatic send_random_set(input int unsigned len);
        logic signed [VAL_W-1:0] seen [$];
        logic signed [VAL_W-1:0] v;
        logic signed [VAL_W+1:0] c;
        int unsigned             pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 15);
            if (pick < 2 && seen.size() > 0)
            begin
                // plant a complement of an earlier element when it fits
                c = target_q - seen[$urandom_range(0, seen.size() - 1)];
                if (c[VAL_W+1:VAL_W-1] == 3'b000 || c[VAL_W+1:VAL_W-1] == 3'b111)
                    v = c[VAL_W-1:0];
                else
                    v = $urandom;
            end
            else if (pick < 5)
            begin
                v = int'($urandom_range(0, 16)) - 8;
            end
            else if (pick < 7 && seen.size() > 0)
            begin
                v = seen[$urandom_range(0, seen.size() - 1)];
            end
            else if (pick == 7)
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = '0;
                    default: v = -32'sd1;
                endcase
            end
            else
            begin
                v = $urandom;
            end
            seen.push_back(v);
            send_element(v, i == len - 1);
        end
    endtask

    task automatic test_pairs_and_ignored();
        tx_gap_max = 0;
        rx_mode    = 0;
        set_target(33'sd0);
        // pair on the last element
        send_element(32'sd5, 1'b0);
        send_element(-32'sd5, 1'b1);
        // duplicate kept at its first position, then the tail is ignored
        send_element(32'sd3, 1'b0);
        send_element(32'sd3, 1'b0);
        send_element(-32'sd3, 1'b0);
        send_element(32'sd7, 1'b0);
        send_element(-32'sd7, 1'b1);
        // a single element never pairs with itself
        send_element(32'sd0, 1'b1);
        send_element(32'sd1, 1'b0);
        send_element(32'sd2, 1'b1);
    endtask

    task automatic test_extreme_targets();
        tx_gap_max = 3;
        rx_mode    = 1;
        set_target(33'sh0_FFFF_FFFE);
        send_element(32'sh7FFF_FFFF, 1'b0);
        send_element(32'sh7FFF_FFFF, 1'b1);
        // complement of the most negative value is out of 32-bit range
        send_element(32'sh8000_0000, 1'b0);
        send_element(32'sd0, 1'b0);
        send_element(32'sh8000_0000, 1'b1);
        set_target(33'sh1_0000_0000);
        send_element(32'sh8000_0000, 1'b0);
        send_element(32'sh8000_0000, 1'b1);
        send_element(32'sh7FFF_FFFF, 1'b0);
        send_element(-32'sd1, 1'b0);
        send_element(32'sh7FFF_FFFF, 1'b1);
    endtask

    task automatic test_store_capacity();
        tx_gap_max = 10;
        rx_mode    = 2;
        set_target(33'sd0);
        // two dropped elements, the first one would have paired
        for (int k = 1; k <= MAX_ITEMS; k++)
            send_element(k, 1'b0);
        send_element(-32'sd1, 1'b0);
        send_element(-32'sd2, 1'b1);
        // exactly full, no pair
        for (int k = 1; k <= MAX_ITEMS; k++)
            send_element(k, k == MAX_ITEMS);
        // pair found on the last slot, then a dropped tail
        for (int k = 1; k < MAX_ITEMS; k++)
            send_element(k, 1'b0);
        send_element(-32'sd5, 1'b0);
        send_element(32'sd9, 1'b0);
        send_element(-32'sd9, 1'b1);
    endtask

    task automatic test_random_sets();
        logic signed [TGT_W-1:0] t;
        int unsigned             stop_at;
        int unsigned             roll;
        for (int p = 0; p < 8; p++)
        begin
            tx_gap_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 10);
            rx_mode    = (p / 2) % 3;
            case (p)
                0: t = 33'sd0;
                1: t = TGT_W'(int'($urandom_range(0, 40)) - 20);
                2: t = 33'sh0_FFFF_FFFE;
                3: t = 33'sh1_0000_0000;
                4: t = -33'sd1;
                default:
                begin
                    t = {1'($urandom_range(0, 1)), 32'($urandom)};
                    if (t == 33'sh0_FFFF_FFFF)
                        t = 33'sh0_FFFF_FFFE;
                end
            endcase
            set_target(t);
            stop_at = elements_sent + PHASE_ITEMS;
            while (elements_sent < stop_at)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    send_random_set($urandom_range(1, 10));
                else if (roll < 95)
                    send_random_set($urandom_range(11, 40));
                else
                    send_random_set($urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6));
            end
        end
    endtask

    // Receiver stall pattern: runs of stall or no stall of random length.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            case (rx_mode)
                0:
                begin
                    stall_on   = 1'b0;
                    stall_left = $urandom_range(0, 8);
                end
                1:
                begin
                    stall_on   = ($urandom_range(0, 3) == 0);
                    stall_left = $urandom_range(0, 3);
                end
                default:
                begin
                    stall_on   = 1'($urandom_range(0, 1));
                    stall_left = $urandom_range(0, 12);
                end
            endcase
        end
        else
        begin
            stall_left--;
        end
        out_stall <= stall_on;
    end

    always @(posedge clk)
    begin
        set_outcome_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            case (status)
                STATUS_PAIR: pairs_seen++;
                STATUS_NONE: nopair_seen++;
                default:     full_seen++;
            endcase
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status=%0d pos=%0d,%0d",
                                          status, earlier_position, later_position));
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", status, want.status));
                if (earlier_position !== want.earlier)
                    report_mismatch($sformatf("earlier_position %0d, want %0d",
                                              earlier_position, want.earlier));
                if (later_position !== want.later)
                    report_mismatch($sformatf("later_position %0d, want %0d",
                                              later_position, want.later));
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("tb_two_sum_pair_finder: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        clear_store();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pairs_and_ignored();
        test_extreme_targets();
        test_store_capacity();
        test_random_sets();
        drain_block();

        if (pending_outcomes.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));
        $display("summary: %0d elements (%0d looked at) in %0d sets, targets from min to max",
                 elements_sent, elements_used, sets_sent);
        $display("summary: %0d pairs, %0d no pair, %0d capacity exceeded, %0d mismatches",
                 pairs_seen, nopair_seen, full_seen, error_count);
        if (error_count == 0)
            $display("tb_two_sum_pair_finder: clean");
        else
            $display("tb_two_sum_pair_finder: errors");
        $finish;
    end

endmodule
